@@ rtl/core/wildcard_glob_matcher_unit_macros.svh @@
// Assertion helpers shared by the matcher RTL
`ifndef WILDCARD_GLOB_MATCHER_UNIT_MACROS_SVH
`define WILDCARD_GLOB_MATCHER_UNIT_MACROS_SVH

// same-cycle implication
`define WGM_ASSERT_NOW(lbl, ck, rn, ant, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ant) |-> (cons)) \
        else $error("wgm check failed");

// next-cycle implication
`define WGM_ASSERT_NEXT(lbl, ck, rn, ant, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ant) |=> (cons)) \
        else $error("wgm check failed");

`endif

@@ rtl/core/wgm_pkg.sv @@
`default_nettype none

package wgm_pkg;

    localparam int MAX_PATTERN_DEF = 32;

    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_QUEST  = 8'h3F;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    // request commands
    typedef enum logic [1:0] {
        CMD_CLEAR   = 2'd0,
        CMD_APPEND  = 2'd1,
        CMD_SUBJECT = 2'd2,
        CMD_REPORT  = 2'd3
    } cmd_t;

    // pattern element kinds
    typedef enum logic [1:0] {
        KIND_LIT  = 2'd0,
        KIND_ANY  = 2'd1,
        KIND_STAR = 2'd2
    } kind_t;

    // broadcast from the top level to every cell
    typedef struct packed {
        logic       restart;    // back to position zero only
        logic       step;       // advance on a subject byte
        logic [7:0] subj_byte;  // folded subject byte
        kind_t      elem_kind;  // element being stored
        logic [7:0] elem_byte;  // folded literal byte
    } cell_ctl_t;

    // ASCII-only lower-case folding
    function automatic logic [7:0] fold(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5A)
        begin
            r = c + 8'h20;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/wgm_cell.sv @@
`default_nettype none

// One pattern position: holds its element and its active bit.
module wgm_cell #(
    parameter logic ACT_RESET = 1'b0
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wgm_pkg::cell_ctl_t  ctl,
    input  wire                 wr_en,     // store the broadcast element here
    input  wire                 in_range,  // position lies below the pattern length
    input  wire                 is_tail,   // pending escape acts as literal backslash here
    input  wire                 carry_in,  // star closure from the left neighbor
    input  wire                 adv_in,    // advance from the left neighbor
    output logic                carry_out,
    output logic                adv_out,
    output logic                closed
);

    logic              act_reg;
    logic              act_next;
    wgm_pkg::kind_t    kind_reg;
    logic [7:0]        byte_reg;
    wgm_pkg::kind_t    eff_kind;
    logic [7:0]        eff_byte;
    logic              is_star;
    logic              consumes;
    logic              self_keep;

    // element store, written by an append that stores an element at this position
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            kind_reg <= ctl.elem_kind;
            byte_reg <= ctl.elem_byte;
        end
    end

    // effective element, with the pending-escape tail
    always_comb
    begin
        eff_kind = is_tail ? wgm_pkg::KIND_LIT : kind_reg;
        eff_byte = is_tail ? wgm_pkg::CH_BSLASH : byte_reg;
    end

    // match decision for this position
    always_comb
    begin
        is_star  = 1'b0;
        consumes = 1'b0;
        case (eff_kind)
            wgm_pkg::KIND_STAR: is_star  = 1'b1;
            wgm_pkg::KIND_ANY:  consumes = 1'b1;
            wgm_pkg::KIND_LIT:  consumes = (eff_byte == ctl.subj_byte);
            default:            consumes = 1'b0;
        endcase
    end

    // closure and hand-off to the right neighbor
    always_comb
    begin
        closed    = act_reg | carry_in;
        carry_out = closed & in_range & is_star;
        self_keep = closed & in_range & is_star;
        adv_out   = closed & in_range & consumes;
    end

    always_comb
    begin
        act_next = act_reg;
        if (ctl.restart)
        begin
            act_next = ACT_RESET;
        end
        else if (ctl.step)
        begin
            act_next = self_keep | adv_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg <= ACT_RESET;
        end
        else
        begin
            act_reg <= act_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/wildcard_glob_matcher_unit.sv @@
// Channel   | Dir | Handshake         | Payload
// ----------+-----+-------------------+----------------------------------------
// slave     | in  | s_tvalid/s_tready | s_tuser[1:0] command, s_tdata data_byte
// master    | out | m_tvalid/m_tready | m_tdata[0] matched, m_tuser[0] overflow
//
// One request per cycle is sustained while no waiting report holds the slave side.
// A report appears on the master side the cycle after it is accepted.
// Star closure ripples through the row of cells in the same cycle as the step.
// A waiting report stalls the slave side only while m_tready is low.
// Reset clears the pattern and the output register and returns the active set to position zero.
`default_nettype none

`include "wildcard_glob_matcher_unit_macros.svh"

module wildcard_glob_matcher_unit #(
    parameter int MAX_PATTERN = wgm_pkg::MAX_PATTERN_DEF
) (
    input  wire        clk,
    input  wire        rst_n,
    input  wire        s_tvalid,
    output logic       s_tready,
    input  wire  [7:0] s_tdata,   // [7:0] data_byte
    input  wire  [1:0] s_tuser,   // [1:0] command
    output logic       m_tvalid,
    input  wire        m_tready,
    output logic [7:0] m_tdata,   // [0] matched, [7:1] zero
    output logic [0:0] m_tuser    // [0] pattern_overflow
);

    localparam int CW = $clog2(MAX_PATTERN + 1);

    logic [CW-1:0]        count_reg, count_next;
    logic                 esc_reg, esc_next;
    logic                 ovf_reg, ovf_next;
    logic                 act_top_reg, act_top_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 out_match_reg, out_match_next;
    logic                 out_ovf_reg, out_ovf_next;

    logic                 s_acc;
    wgm_pkg::cmd_t        cmd;
    logic [7:0]           byte_in;
    logic                 has_room;
    logic                 elem_valid;
    logic                 store_fire;
    logic [CW-1:0]        len;
    logic                 eff_ovf;
    logic                 hit;
    wgm_pkg::cell_ctl_t   ctl;

    logic [MAX_PATTERN:0]   carry;
    logic [MAX_PATTERN:0]   adv;
    logic [MAX_PATTERN:0]   closed;
    logic [MAX_PATTERN-1:0] wr_en;

    // request decode
    always_comb
    begin
        s_acc    = s_tvalid & s_tready;
        cmd      = wgm_pkg::cmd_t'(s_tuser);
        byte_in  = s_tdata;
        has_room = (count_reg < CW'(MAX_PATTERN));
        len      = (esc_reg && has_room) ? count_reg + CW'(1) : count_reg;
        eff_ovf  = ovf_reg | (esc_reg & ~has_room);
    end

    // element build for an append request, plus the subject byte and the restart and step controls
    always_comb
    begin
        ctl           = '0;
        elem_valid    = 1'b1;
        ctl.subj_byte = wgm_pkg::fold(byte_in);
        ctl.elem_kind = wgm_pkg::KIND_LIT;
        ctl.elem_byte = wgm_pkg::fold(byte_in);
        if (esc_reg)
        begin
            ctl.elem_kind = wgm_pkg::KIND_LIT;
        end
        else if (byte_in == wgm_pkg::CH_BSLASH)
        begin
            elem_valid = 1'b0;
        end
        else if (byte_in == wgm_pkg::CH_STAR)
        begin
            ctl.elem_kind = wgm_pkg::KIND_STAR;
            ctl.elem_byte = '0;
        end
        else if (byte_in == wgm_pkg::CH_QUEST)
        begin
            ctl.elem_kind = wgm_pkg::KIND_ANY;
            ctl.elem_byte = '0;
        end
        ctl.restart = s_acc && (cmd inside {wgm_pkg::CMD_CLEAR, wgm_pkg::CMD_APPEND,
                                            wgm_pkg::CMD_REPORT});
        ctl.step    = s_acc && (cmd == wgm_pkg::CMD_SUBJECT);
    end

    assign store_fire = s_acc && (cmd == wgm_pkg::CMD_APPEND) && elem_valid && has_room;

    // row of cells with the closure chain running left to right
    assign carry[0] = 1'b0;
    assign adv[0]   = 1'b0;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_PATTERN; gi++)
        begin : g_cell
            assign wr_en[gi] = store_fire && (count_reg == CW'(gi));

            wgm_cell #(
                .ACT_RESET ((gi == 0) ? 1'b1 : 1'b0)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctl       (ctl),
                .wr_en     (wr_en[gi]),
                .in_range  (len > CW'(gi)),
                .is_tail   (esc_reg && (count_reg == CW'(gi))),
                .carry_in  (carry[gi]),
                .adv_in    (adv[gi]),
                .carry_out (carry[gi+1]),
                .adv_out   (adv[gi+1]),
                .closed    (closed[gi])
            );
        end
    endgenerate

    // position past the last element
    assign closed[MAX_PATTERN] = act_top_reg | carry[MAX_PATTERN];
    assign hit = closed[len];

    // pattern and tracking state
    always_comb
    begin
        count_next   = count_reg;
        esc_next     = esc_reg;
        ovf_next     = ovf_reg;
        act_top_next = act_top_reg;
        if (ctl.restart)
        begin
            act_top_next = 1'b0;
        end
        else if (ctl.step)
        begin
            act_top_next = adv[MAX_PATTERN];
        end
        if (s_acc && cmd == wgm_pkg::CMD_CLEAR)
        begin
            count_next = '0;
            esc_next   = 1'b0;
            ovf_next   = 1'b0;
        end
        else if (s_acc && cmd == wgm_pkg::CMD_APPEND)
        begin
            esc_next = esc_reg ? 1'b0 : ~elem_valid;
            if (elem_valid)
            begin
                if (has_room)
                begin
                    count_next = count_reg + CW'(1);
                end
                else
                begin
                    ovf_next = 1'b1;
                end
            end
        end
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_match_next = out_match_reg;
        out_ovf_next   = out_ovf_reg;
        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (s_acc && cmd == wgm_pkg::CMD_REPORT)
        begin
            out_valid_next = 1'b1;
            out_match_next = hit & ~eff_ovf;
            out_ovf_next   = eff_ovf;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            esc_reg       <= 1'b0;
            ovf_reg       <= 1'b0;
            act_top_reg   <= (MAX_PATTERN == 0);
            out_valid_reg <= 1'b0;
            out_match_reg <= 1'b0;
            out_ovf_reg   <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            esc_reg       <= esc_next;
            ovf_reg       <= ovf_next;
            act_top_reg   <= act_top_next;
            out_valid_reg <= out_valid_next;
            out_match_reg <= out_match_next;
            out_ovf_reg   <= out_ovf_next;
        end
    end

    // ports
    assign s_tready = ~out_valid_reg | m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0, out_match_reg};
    assign m_tuser  = out_ovf_reg;

    // checks
    `WGM_ASSERT_NEXT(a_report_shows, clk, rst_n, s_acc && cmd == wgm_pkg::CMD_REPORT, m_tvalid)
    `WGM_ASSERT_NOW(a_ovf_no_match, clk, rst_n, m_tvalid && m_tuser[0], !m_tdata[0])
    `WGM_ASSERT_NEXT(a_clear_empties, clk, rst_n, s_acc && cmd == wgm_pkg::CMD_CLEAR, count_reg == '0 && !ovf_reg && !esc_reg)
    `WGM_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_reg <= CW'(MAX_PATTERN))
    `WGM_ASSERT_NOW(a_ovf_full, clk, rst_n, ovf_reg, count_reg == CW'(MAX_PATTERN))

endmodule

`default_nettype wire
